### rtl/core/spq_pkg.sv
package spq_pkg;

    // Key format: signed 16.16 fixed point.
    localparam int KEY_W = 32;

    // Request codes.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DRAIN  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_DRAIN = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;    // place the new word in order, shifting the tail up
        logic rot;    // rotate the ring one place toward cell zero
    } cell_cmd_t;

endpackage

### rtl/core/spq_cell.sv
module spq_cell #(
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                            clk,
    input  spq_pkg::cell_cmd_t              cmd,
    input  logic                            occ,
    input  logic signed [spq_pkg::KEY_W-1:0] new_key,
    input  logic [PAYLOAD_WIDTH-1:0]        new_payload,
    input  logic                            prev_gt,
    input  logic signed [spq_pkg::KEY_W-1:0] prev_key,
    input  logic [PAYLOAD_WIDTH-1:0]        prev_payload,
    input  logic signed [spq_pkg::KEY_W-1:0] next_key,
    input  logic [PAYLOAD_WIDTH-1:0]        next_payload,
    output logic                            gt,
    output logic signed [spq_pkg::KEY_W-1:0] key,
    output logic [PAYLOAD_WIDTH-1:0]        payload
);
    import spq_pkg::*;

    logic signed [KEY_W-1:0]  key_reg;
    logic signed [KEY_W-1:0]  key_next;
    logic [PAYLOAD_WIDTH-1:0] payload_reg;
    logic [PAYLOAD_WIDTH-1:0] payload_next;

    // The new word goes before this entry when the stored key is strictly greater,
    // so equal keys keep their arrival order.
    assign gt = occ && (key_reg > new_key);

    // Shift from the lower neighbor, take the new word, or rotate from the upper one.
    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (cmd.ins)
        begin
            if (prev_gt)
            begin
                key_next     = prev_key;
                payload_next = prev_payload;
            end
            else if (gt || !occ)
            begin
                key_next     = new_key;
                payload_next = new_payload;
            end
        end
        else if (cmd.rot)
        begin
            key_next     = next_key;
            payload_next = next_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;

endmodule

### rtl/core/stable_sorted_priority_queue_unit.sv
// Sorted priority queue built as a chain of DEPTH cells, kept in ascending key
// order; equal keys stay in arrival order.
// Input channel (in_valid / in_stall) carries req_type, key and payload. An
// insert word compares its key in every cell at once and is written into the chain;
// it returns one result word (status ok, or full when DEPTH entries are held,
// in which case it is dropped) with last set.
// A drain word rotates the cell ring once round, emitting the entry in cell zero
// at each of the first entry_count steps; the last one has last
// set. An empty queue drains nothing. Stored entries are kept.
// Output channel (out_valid / out_stall) is fed from an output register, so an
// insert result appears in the cycle after its request; the first drained entry
// passes through the sequencer state, then the output register. Throughput: one
// insert per cycle while the receiver takes results; a drain holds the input
// until the ring has turned once round, longer while the receiver stalls, since the
// ring only advances past an occupied entry when the output register can take it.
// Reset clears the entry count, the sequencer and the output valid; cell
// contents are left as they are.
module stable_sorted_priority_queue_unit #(
    parameter int DEPTH         = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             req_type,
    input  logic signed [spq_pkg::KEY_W-1:0] key,
    input  logic [31:0]                      payload,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       status,
    output logic signed [spq_pkg::KEY_W-1:0] out_key,
    output logic [31:0]                      out_payload,
    output logic                             last
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    state_t           state_reg;
    state_t           state_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic [31:0]      payload_reg;
    logic [31:0]      payload_next;
    logic             last_reg;
    logic             last_next;

    logic             slot_free;
    logic             in_acc;
    logic             full;
    logic             emit;
    logic [CNT_W-1:0] idx_ext;
    cell_cmd_t        cmd;

    logic [63:0]              pay_in_ext;
    logic [PAYLOAD_WIDTH-1:0] new_payload;
    logic [63:0]              pay_out_ext;

    logic signed [KEY_W-1:0]  cell_key [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] cell_pay [DEPTH];
    logic [DEPTH-1:0]         cell_gt;

    // Only the low PAYLOAD_WIDTH bits of a payload are stored.
    assign pay_in_ext  = 64'(payload);
    assign new_payload = pay_in_ext[PAYLOAD_WIDTH-1:0];
    assign pay_out_ext = 64'(cell_pay[0]);

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !slot_free;
    assign in_acc    = in_valid && !in_stall;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign idx_ext   = CNT_W'(idx_reg);

    // The chain of cells; cell zero is the head of the ring.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? 0 : i - 1;
        localparam int NEXT = (i == DEPTH - 1) ? 0 : i + 1;
        logic prev_gt;

        assign prev_gt = (i == 0) ? 1'b0 : cell_gt[PREV];

        spq_cell #(
            .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occ         (CNT_W'(i) < count_reg),
            .new_key     (key),
            .new_payload (new_payload),
            .prev_gt     (prev_gt),
            .prev_key    (cell_key[PREV]),
            .prev_payload(cell_pay[PREV]),
            .next_key    (cell_key[NEXT]),
            .next_payload(cell_pay[NEXT]),
            .gt          (cell_gt[i]),
            .key         (cell_key[i]),
            .payload     (cell_pay[i])
        );
    end

    // Sequencer, entry count and output register.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        key_next       = key_reg;
        payload_next   = payload_reg;
        last_next      = last_reg;
        cmd            = '0;
        emit           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && req_type == REQ_INSERT)
                begin
                    out_valid_next = 1'b1;
                    key_next       = '0;
                    payload_next   = '0;
                    last_next      = 1'b1;
                    if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        cmd.ins     = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                end
                else if (in_acc && req_type == REQ_DRAIN && count_reg != '0)
                begin
                    state_next = ST_DRAIN;
                    idx_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                // Occupied entries wait for the output register; the rest rotate freely.
                if (idx_ext < count_reg)
                begin
                    emit    = slot_free;
                    cmd.rot = slot_free;
                end
                else
                begin
                    cmd.rot = 1'b1;
                end
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STATUS_DRAIN;
                    key_next       = cell_key[0];
                    payload_next   = pay_out_ext[31:0];
                    last_next      = (idx_ext + 1'b1 == count_reg);
                end
                if (cmd.rot)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(DEPTH - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        key_reg     <= key_next;
        payload_reg <= payload_next;
        last_reg    <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_key     = key_reg;
    assign out_payload = payload_reg;
    assign last        = last_reg;

    // The entry count never passes the chain length.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // An accepted insert shows its single result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && req_type == REQ_INSERT |=> out_valid && last)
        else $error("insert result missing");

    // A drain leaves the entry count untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |=> $stable(count_reg))
        else $error("entry count changed during drain");

endmodule

### tb/tb_stable_sorted_priority_queue_unit.sv
module tb_stable_sorted_priority_queue_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int DEPTH         = 32;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int RANDOM_WORDS  = 217;
    localparam int LONG_HOLD     = 300;
    localparam int IDLE_LIMIT    = 5000;

    // One result word as the block should present it.
    typedef struct {
        status_t                   status;
        logic signed [KEY_W-1:0]   key;
        logic [31:0]               payload;
        logic                      last;
    } result_word_t;

    // Keeps its own sorted copy of the queue and the result words still due.
    class queue_scoreboard;
        logic signed [KEY_W-1:0] sorted_keys[$];
        logic [31:0]             sorted_payloads[$];
        result_word_t            due_words[$];
        int                      errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function void push_due(status_t st, logic signed [KEY_W-1:0] k, logic [31:0] p,
                               logic lst);
            result_word_t w;
            w.status  = st;
            w.key     = k;
            w.payload = p;
            w.last    = lst;
            due_words.push_back(w);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t ns: %s", $time, what);
            errors++;
        endtask

        // An accepted request word: update the sorted copy and queue its results.
        task note_request(logic req, logic signed [KEY_W-1:0] k, logic [31:0] p);
            int pos;
            if (req == REQ_INSERT)
            begin
                if (sorted_keys.size() >= DEPTH)
                begin
                    push_due(STATUS_FULL, '0, '0, 1'b1);
                end
                else
                begin
                    // A new entry goes after every stored entry with a key not above it.
                    pos = 0;
                    while (pos < sorted_keys.size() && sorted_keys[pos] <= k)
                        pos++;
                    sorted_keys.insert(pos, k);
                    sorted_payloads.insert(pos, p);
                    push_due(STATUS_OK, '0, '0, 1'b1);
                end
            end
            else
            begin
                // A drain lists every entry in order and removes none.
                for (int i = 0; i < sorted_keys.size(); i++)
                    push_due(STATUS_DRAIN, sorted_keys[i], sorted_payloads[i],
                             (i == sorted_keys.size() - 1));
            end
        endtask

        // An accepted result word: compare it with the oldest one due.
        task check_result(logic [1:0] st, logic signed [KEY_W-1:0] k, logic [31:0] p,
                          logic lst);
            result_word_t w;
            if (due_words.size() == 0)
            begin
                report_mismatch($sformatf("result word with none due: status %0d key %h",
                                          st, k));
                return;
            end
            w = due_words.pop_front();
            if (st !== w.status)
                report_mismatch($sformatf("status %0d, wanted %0d", st, w.status));
            if (k !== w.key)
                report_mismatch($sformatf("out_key %h, wanted %h", k, w.key));
            if (p !== w.payload)
                report_mismatch($sformatf("out_payload %h, wanted %h", p, w.payload));
            if (lst !== w.last)
                report_mismatch($sformatf("last %b, wanted %b", lst, w.last));
        endtask
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    req_type;
    logic signed [KEY_W-1:0] key;
    logic [31:0]             payload;
    logic                    out_valid;
    logic                    out_stall;
    logic [1:0]              status;
    logic signed [KEY_W-1:0] out_key;
    logic [31:0]             out_payload;
    logic                    last;

    queue_scoreboard sb = new();
    bit              hold_request = 1'b0;
    int              idle_cycles  = 0;

    stable_sorted_priority_queue_unit #(
        .DEPTH         (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .key         (key),
        .payload     (payload),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_key     (out_key),
        .out_payload (out_payload),
        .last        (last)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Keys lean toward repeats and extremes so that ties and ordering get exercised.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom;
        if (r < 70)
            return ($signed($urandom_range(0, 4)) - 2) <<< 16;
        if (r < 80)
            return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        return $signed($urandom_range(0, 7)) - 4;
    endfunction

    // Offer one request word after a random gap and wait until it is taken.
    task automatic send_word(logic req, logic signed [KEY_W-1:0] k, logic [31:0] p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            req_type <= $urandom_range(0, 1);
            key      <= $urandom;
            payload  <= $urandom;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        key      <= k;
        payload  <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Result check first, then the new request, so the order of expectations holds.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(status, out_key, out_payload, last);
            if (in_valid && !in_stall)
                sb.note_request(req_type, key, payload);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall runs, and one long hold-off on request.
    initial
    begin
        int stall_len;
        int run_len;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall_len = pick_gap();
            run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : pick_gap() + 1;
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat (run_len) @(posedge clk);
        end
    end

    // Watchdog: too long without any word moving ends the run.
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    // Reset, directed words, random words, then wait for the last results.
    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        req_type <= REQ_INSERT;
        key      <= '0;
        payload  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Drain of an empty queue gives nothing.
        send_word(REQ_DRAIN, 32'sh0, 32'h0);
        // Key and payload extremes, negative and fractional keys.
        send_word(REQ_INSERT, 32'sh0000_0000, 32'h0000_0000);
        send_word(REQ_INSERT, 32'sh8000_0000, 32'hFFFF_FFFF);
        send_word(REQ_INSERT, 32'sh7FFF_FFFF, 32'hA5A5_5A5A);
        send_word(REQ_INSERT, -32'sd1, 32'h5A5A_A5A5);
        // Equal keys must keep arrival order, at the head, middle and tail.
        send_word(REQ_INSERT, 32'sh0000_0000, 32'h0000_0001);
        send_word(REQ_INSERT, 32'sh0000_0000, 32'h0000_0002);
        send_word(REQ_INSERT, 32'sh0001_0000, 32'h0000_0003);
        send_word(REQ_INSERT, 32'sh8000_0000, 32'h0000_0004);
        send_word(REQ_INSERT, 32'sh7FFF_FFFF, 32'h0000_0005);
        send_word(REQ_DRAIN, 32'sh1234_5678, 32'h9ABC_DEF0);
        send_word(REQ_INSERT, 32'sh0000_8000, 32'h0000_0006);
        send_word(REQ_DRAIN, 32'sh0, 32'h0);

        // Random part; the queue fills up and later inserts see the full case.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == 40)
                hold_request = 1'b1;
            send_word(($urandom_range(0, 3) == 0) ? REQ_DRAIN : REQ_INSERT,
                      pick_key(), $urandom);
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DEPTH + 16) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_sorted_priority_queue_unit.sv
tb/tb_stable_sorted_priority_queue_unit.sv
